### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is held
`define CLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that holds at every edge, reset included
`define CLT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// types and constants of the compacting list table
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  // common width for comparing and resizing counts and positions
  localparam int unsigned XW      = (CW > 5) ? CW : 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [1:0] {
    KIND_APPEND       = 2'd0,
    KIND_FIND         = 2'd1,
    KIND_REMOVE_VALUE = 2'd2,
    KIND_REMOVE_AT    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

endpackage

### hw/rtl/compacting_list_table_unit.sv
// append and rejected requests go straight to the finish state; find scans from
//   position zero until a hit or the end of the list; remove then compacts the
//   entries behind the removed one after the search or position check
// one request at a time: the input stalls until the unit is back in idle; the
//   search and compaction of a remove by value share the single ram read port
// reset clears the entry count and control state; stored entries are not cleared
// ----------------------------------------------------------------------------
// compacting_list_table_unit
// ordered list with append, find, remove by value and remove at position
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module compacting_list_table_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  clt_pkg::kind_e                       kind_i,
  input  logic signed [clt_pkg::VALUE_W-1:0]   value_i,
  input  logic [clt_pkg::POS_W-1:0]            position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output clt_pkg::status_e                     status_o,
  output logic [clt_pkg::POS_W-1:0]            found_position_o,
  output logic [clt_pkg::CNT_W-1:0]            entry_count_o,
  output logic                                 is_empty_o
);

  import clt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  kind_e                     kind_q, kind_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic                      chk_q, chk_d;
  logic [AW-1:0]             chk_idx_q, chk_idx_d;
  logic [CW-1:0]             sh_rd_q, sh_rd_d;
  logic                      wr_pend_q, wr_pend_d;
  logic [AW-1:0]             wr_idx_q, wr_idx_d;
  logic [AW-1:0]             where_q, where_d;
  status_e                   res_status_q, res_status_d;
  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic [POS_W-1:0]          found_pos_q, found_pos_d;
  logic [CNT_W-1:0]          entry_count_q, entry_count_d;
  logic                      is_empty_q, is_empty_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic                      rd_en;

  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;
  logic [XW-1:0]             where_x;
  logic [CW-1:0]             sh_prev;

  assign pos_x   = XW'(position_i);
  assign count_x = XW'(count_q);
  assign where_x = XW'(where_q);
  assign sh_prev = sh_rd_q - CW'(1);

  clt_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    kind_d        = kind_q;
    val_d         = val_q;
    idx_d         = idx_q;
    chk_d         = chk_q;
    chk_idx_d     = chk_idx_q;
    sh_rd_d       = sh_rd_q;
    wr_pend_d     = wr_pend_q;
    wr_idx_d      = wr_idx_q;
    where_d       = where_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    found_pos_d   = found_pos_q;
    entry_count_d = entry_count_q;
    is_empty_d    = is_empty_q;

    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = value_i;
    ram_raddr = idx_q[AW-1:0];
    rd_en     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          val_d  = value_i;
          case (kind_i)
            KIND_APPEND: begin
              if (count_q >= CW'(DEPTH)) begin
                res_status_d = STATUS_FULL;
                where_d      = '0;
              end else begin
                ram_we       = 1'b1;
                where_d      = count_q[AW-1:0];
                count_d      = count_q + CW'(1);
                res_status_d = STATUS_OK;
              end
              state_d = ST_FINISH;
            end
            KIND_FIND, KIND_REMOVE_VALUE: begin
              idx_d   = '0;
              chk_d   = 1'b0;
              state_d = ST_SCAN;
            end
            KIND_REMOVE_AT: begin
              if (pos_x >= count_x) begin
                res_status_d = STATUS_MISSING;
                where_d      = '0;
                state_d      = ST_FINISH;
              end else begin
                where_d   = pos_x[AW-1:0];
                sh_rd_d   = pos_x[CW-1:0] + CW'(1);
                wr_pend_d = 1'b0;
                state_d   = ST_SHIFT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // compare acts on the entry whose address was issued in the cycle before
        if (chk_q && (ram_rdata == val_q)) begin
          chk_d   = 1'b0;
          where_d = chk_idx_q;
          if (kind_q == KIND_FIND) begin
            res_status_d = STATUS_OK;
            state_d      = ST_FINISH;
          end else begin
            sh_rd_d   = CW'(chk_idx_q) + CW'(1);
            wr_pend_d = 1'b0;
            state_d   = ST_SHIFT;
          end
        end else if (idx_q >= count_q) begin
          chk_d        = 1'b0;
          where_d      = '0;
          res_status_d = STATUS_MISSING;
          state_d      = ST_FINISH;
        end else begin
          rd_en     = 1'b1;
          ram_raddr = idx_q[AW-1:0];
          chk_d     = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end
      end

      ST_SHIFT: begin
        // entry read last cycle moves one place down
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx_q;
          ram_wdata = ram_rdata;
        end
        if (sh_rd_q < count_q) begin
          rd_en     = 1'b1;
          ram_raddr = sh_rd_q[AW-1:0];
          wr_pend_d = 1'b1;
          wr_idx_d  = sh_prev[AW-1:0];
          sh_rd_d   = sh_rd_q + CW'(1);
        end else begin
          wr_pend_d    = 1'b0;
          count_d      = count_q - CW'(1);
          res_status_d = STATUS_OK;
          state_d      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          status_d      = res_status_q;
          found_pos_d   = where_x[POS_W-1:0];
          entry_count_d = count_x[CNT_W-1:0];
          is_empty_d    = (count_q == '0);
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      kind_q        <= KIND_APPEND;
      val_q         <= '0;
      idx_q         <= '0;
      chk_q         <= 1'b0;
      chk_idx_q     <= '0;
      sh_rd_q       <= '0;
      wr_pend_q     <= 1'b0;
      wr_idx_q      <= '0;
      where_q       <= '0;
      res_status_q  <= STATUS_OK;
      out_valid_q   <= 1'b0;
      status_q      <= STATUS_OK;
      found_pos_q   <= '0;
      entry_count_q <= '0;
      is_empty_q    <= 1'b1;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      kind_q        <= kind_d;
      val_q         <= val_d;
      idx_q         <= idx_d;
      chk_q         <= chk_d;
      chk_idx_q     <= chk_idx_d;
      sh_rd_q       <= sh_rd_d;
      wr_pend_q     <= wr_pend_d;
      wr_idx_q      <= wr_idx_d;
      where_q       <= where_d;
      res_status_q  <= res_status_d;
      out_valid_q   <= out_valid_d;
      status_q      <= status_d;
      found_pos_q   <= found_pos_d;
      entry_count_q <= entry_count_d;
      is_empty_q    <= is_empty_d;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_pos_q;
  assign entry_count_o    = entry_count_q;
  assign is_empty_o       = is_empty_q;

  `CLT_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `CLT_ASSERT(a_no_overlap,
              (ram_we && rd_en) |-> (ram_waddr != ram_raddr),
              "ram read and write collide")
  `CLT_ASSERT(a_result_from_finish,
              $rose(out_valid_q) |-> $past(state_q == ST_FINISH),
              "result without finish")
  `CLT_ASSERT(a_count_step,
              (count_q != $past(count_q)) |->
                ((count_q == $past(count_q) + CW'(1)) ||
                 (count_q == $past(count_q) - CW'(1))),
              "entry count jumped")

endmodule

### hw/rtl/clt_ram.sv
// ----------------------------------------------------------------------------
// clt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module clt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
